### rtl/bpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the bitmap page allocator: operation and
// status codes, configuration register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package bpa_pkg;

	// page geometry, addresses are 32 bits so page numbers of sums need 21
	localparam int PAGE_SHIFT = 12;
	localparam int PAGE_MASK  = 4095;
	localparam int PG_W       = 21;
	localparam int BYTE_W     = PG_W - 3;

	// the low 1 MiB, in bytes and in pages
	localparam logic [31:0]     LOW_MEM_BYTES = 32'h0010_0000;
	localparam logic [PG_W-1:0] LOW_MEM_PAGES = 21'd256;

	localparam logic [7:0] BYTE_FULL = 8'hFF;

	// operation codes
	localparam logic [2:0] OP_MARK_ALL = 3'd0;
	localparam logic [2:0] OP_RELEASE  = 3'd1;
	localparam logic [2:0] OP_FINISH   = 3'd2;
	localparam logic [2:0] OP_ALLOC    = 3'd3;
	localparam logic [2:0] OP_FREE     = 3'd4;

	// result status codes
	localparam logic [1:0] STAT_DONE    = 2'd0;
	localparam logic [1:0] STAT_OOM     = 2'd1;
	localparam logic [1:0] STAT_IGNORED = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_PAGE_COUNT   = 3'd0;
	localparam logic [2:0] CFG_KERNEL_START = 3'd1;
	localparam logic [2:0] CFG_KERNEL_END   = 3'd2;
	localparam logic [2:0] CFG_META_BASE    = 3'd3;
	localparam logic [2:0] CFG_META_BYTES   = 3'd4;

	// configuration reset values
	localparam logic [31:0] KERNEL_START_RST = 32'h0010_0000;
	localparam logic [31:0] KERNEL_END_RST   = 32'h0010_0000;
	localparam logic [31:0] META_BASE_RST    = 32'h0010_0000;
	localparam logic [17:0] META_BYTES_RST   = 18'd8192;

	// reservation phases of the finish operation
	localparam logic [1:0] PH_KERNEL = 2'd0;
	localparam logic [1:0] PH_META   = 2'd1;
	localparam logic [1:0] PH_LOW    = 2'd2;

	// sequencer states
	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_SETUP,
		S_FILL,
		S_RNG_RD,
		S_RNG_WR,
		S_ALLOC_RD,
		S_ALLOC_CHK,
		S_DONE
	} state_t;

endpackage

### rtl/bpa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_if
// Valid/ready channels of the bitmap page allocator: the request channel
// and the response channel, each with a source and a sink side.
// ----------------------------------------------------------------------------
interface bpa_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [31:0] addr;
	logic [31:0] length;

	modport source (output valid, output op, output addr, output length, input ready);
	modport sink   (input valid, input op, input addr, input length, output ready);
endinterface

interface bpa_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] page_addr;
	logic [1:0]  status;

	modport source (output valid, output page_addr, output status, input ready);
	modport sink   (input valid, input page_addr, input status, output ready);
endinterface

### rtl/bpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/bitmap_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// Next-fit bitmap allocator for 4 KiB physical pages, one bit per page.
// ----------------------------------------------------------------------------
// The used map lives in a byte-wide RAM of (MAX_PAGES+7)/8 entries and every
// operation walks it through the RAM's write and read ports, both addressed
// by one byte pointer, under a small sequencer, one request at a time. After
// reset a clearing pass writes all ones to the map, during which no request
// is accepted (configuration writes are taken). From request transfer to
// response valid: mark all used writes each map byte in turn; release and
// free read and then write each map byte touched (free touches one byte,
// none when ignored); finish does the same after a setup step for each of
// its three ranges; allocate reads and checks each map byte scanned, so its
// time grows with occupancy; other codes go straight to the response. A
// finished request waits while the output register still holds an
// unaccepted response, but that waiting response does not block the
// transfer of the next request.
// ----------------------------------------------------------------------------
module bitmap_page_allocator
	import bpa_pkg::*;
#(
	parameter int MAX_PAGES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	bpa_req_if.sink     req,
	bpa_rsp_if.source   rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int MAP_CAP  = (MAX_PAGES + 7) / 8;
	localparam int BYTE_AW  = $clog2(MAP_CAP);
	localparam int NB_W     = BYTE_AW + 1;
	localparam int PCOV_W   = $clog2(MAX_PAGES) + 1;
	localparam int PCOV_RST = (MAX_PAGES < 65536) ? MAX_PAGES : 65536;

	state_t state_q, state_d;

	// configuration
	logic [PCOV_W-1:0] pcov_q;
	logic [31:0]       ks_q, ke_q, mb_q;
	logic [17:0]       mbytes_q;

	// request and sequencer registers
	logic [2:0]        op_q;
	logic [31:0]       addr_q, length_q;
	logic [1:0]        phase_q;
	logic [BYTE_W-1:0] byte_q, end_byte_q;
	logic [2:0]        first_bit_q, last_bit_q;
	logic              first_flag_q;
	logic [NB_W-1:0]   cnt_q;
	logic [BYTE_AW-1:0] ssb_q;
	logic [31:0]       res_addr_q;
	logic [1:0]        res_status_q;

	// output register
	logic              rsp_valid_q;
	logic [31:0]       rsp_page_addr_q;
	logic [1:0]        rsp_status_q;

	// ram
	logic              ram_we;
	logic [7:0]        ram_wdata, ram_rdata;

	// lowest clear bit of a byte
	function automatic logic [2:0] lowest_clear(input logic [7:0] v);
		logic [2:0] b;
		b = 3'd0;
		for (int j = 7; j >= 0; j--) begin
			if (!v[j]) b = 3'(j);
		end
		return b;
	endfunction

	// bits lo..hi of a byte
	function automatic logic [7:0] range_mask(input logic [2:0] lo, input logic [2:0] hi);
		logic [7:0] m;
		for (int j = 0; j < 8; j++) begin
			m[j] = (3'(j) >= lo) && (3'(j) <= hi);
		end
		return m;
	endfunction

	// map geometry from the page count
	logic [PCOV_W:0]   nb_sum;
	logic [NB_W-1:0]   nbytes;
	logic [PG_W-1:0]   lim_pages;
	logic              nb_zero;

	assign nb_sum    = {1'b0, pcov_q} + (PCOV_W + 1)'(7);
	assign nbytes    = NB_W'(nb_sum >> 3);
	assign lim_pages = PG_W'({nbytes, 3'b000});
	assign nb_zero   = (nbytes == '0);

	// page range of the current operation or finish phase
	logic [32:0]     sum_a, sum_e, sum_k, sum_m, meta_end;
	logic [PG_W-1:0] rng_first, rng_last, cand_last, cut_cap, last_m1;
	logic            rng_hit, rng_set, more_phase;

	assign sum_a    = {1'b0, addr_q} + 33'(PAGE_MASK);
	assign sum_e    = {1'b0, addr_q} + {1'b0, length_q};
	assign sum_k    = {1'b0, ke_q} + 33'(PAGE_MASK);
	assign meta_end = {1'b0, mb_q} + 33'(mbytes_q);
	assign sum_m    = meta_end + 33'(PAGE_MASK);

	always_comb begin
		rng_first = '0;
		cand_last = '0;
		cut_cap   = lim_pages;
		case (op_q)
			OP_RELEASE: begin
				rng_first = sum_a[32:PAGE_SHIFT];
				cand_last = sum_e[32:PAGE_SHIFT];
				cut_cap   = PG_W'(pcov_q);
			end
			OP_FREE: begin
				rng_first = PG_W'(addr_q[31:PAGE_SHIFT]);
				cand_last = PG_W'(addr_q[31:PAGE_SHIFT]) + PG_W'(1);
				cut_cap   = cand_last;
			end
			OP_FINISH: begin
				case (phase_q)
					PH_KERNEL: begin
						rng_first = PG_W'(ks_q[31:PAGE_SHIFT]);
						cand_last = sum_k[32:PAGE_SHIFT];
					end
					PH_META: begin
						rng_first = PG_W'(mb_q[31:PAGE_SHIFT]);
						cand_last = sum_m[32:PAGE_SHIFT];
					end
					default: begin
						rng_first = '0;
						cand_last = LOW_MEM_PAGES;
					end
				endcase
			end
			default: begin
				rng_first = '0;
				cand_last = '0;
			end
		endcase
	end

	assign rng_last   = (cand_last < cut_cap) ? cand_last : cut_cap;
	assign last_m1    = rng_last - PG_W'(1);
	assign rng_hit    = rng_first < rng_last;
	assign rng_set    = (op_q == OP_FINISH);
	assign more_phase = (op_q == OP_FINISH) && (phase_q != PH_LOW);

	// free request filter
	logic free_bad;

	assign free_bad = (addr_q[PAGE_SHIFT-1:0] != '0) || (addr_q < LOW_MEM_BYTES) ||
		((addr_q >= ks_q) && (addr_q < ke_q)) ||
		(({1'b0, addr_q} >= {1'b0, mb_q}) && ({1'b0, addr_q} < meta_end)) ||
		({1'b0, addr_q[31:PAGE_SHIFT+3]} >= BYTE_W'(nbytes));

	// byte walk helpers
	logic [BYTE_W-1:0] byte_inc, alloc_start, alloc_next;
	logic              fill_last, byte_last, byte_found;
	logic [2:0]        clr_bit, mask_lo, mask_hi;
	logic [7:0]        rmw_mask;

	assign byte_inc    = byte_q + BYTE_W'(1);
	assign fill_last   = (byte_inc == BYTE_W'(nbytes));
	assign byte_last   = (byte_q == end_byte_q);
	assign alloc_start = (NB_W'(ssb_q) < nbytes) ? BYTE_W'(ssb_q) : '0;
	assign alloc_next  = fill_last ? '0 : byte_inc;
	assign byte_found  = (ram_rdata != BYTE_FULL);
	assign clr_bit     = lowest_clear(ram_rdata);
	assign mask_lo     = first_flag_q ? first_bit_q : 3'd0;
	assign mask_hi     = byte_last ? last_bit_q : 3'd7;
	assign rmw_mask    = range_mask(mask_lo, mask_hi);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and ram controls
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_wdata = BYTE_FULL;
		case (state_q)
			S_INIT: begin
				ram_we = 1'b1;
				if (byte_q == BYTE_W'(MAP_CAP - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req.valid) state_d = S_SETUP;
			end
			S_SETUP: begin
				case (op_q)
					OP_MARK_ALL: state_d = nb_zero ? S_DONE : S_FILL;
					OP_ALLOC:    state_d = nb_zero ? S_DONE : S_ALLOC_RD;
					OP_RELEASE, OP_FINISH, OP_FREE: begin
						if ((op_q == OP_FREE) && free_bad) state_d = S_DONE;
						else if (rng_hit)                  state_d = S_RNG_RD;
						else if (more_phase)               state_d = S_SETUP;
						else                               state_d = S_DONE;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_FILL: begin
				ram_we = 1'b1;
				if (fill_last) state_d = S_DONE;
			end
			S_RNG_RD: begin
				state_d = S_RNG_WR;
			end
			S_RNG_WR: begin
				ram_we    = 1'b1;
				ram_wdata = rng_set ? (ram_rdata | rmw_mask) : (ram_rdata & ~rmw_mask);
				if (byte_last) state_d = more_phase ? S_SETUP : S_DONE;
				else           state_d = S_RNG_RD;
			end
			S_ALLOC_RD: begin
				state_d = S_ALLOC_CHK;
			end
			S_ALLOC_CHK: begin
				if (byte_found) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata | (8'd1 << clr_bit);
					state_d   = S_DONE;
				end else if (cnt_q == NB_W'(1)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_ALLOC_RD;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// map storage
	bpa_ram #(
		.WIDTH (8),
		.DEPTH (MAP_CAP)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (byte_q[BYTE_AW-1:0]),
		.wdata (ram_wdata),
		.raddr (byte_q[BYTE_AW-1:0]),
		.rdata (ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcov_q   <= PCOV_W'(PCOV_RST);
			ks_q     <= KERNEL_START_RST;
			ke_q     <= KERNEL_END_RST;
			mb_q     <= META_BASE_RST;
			mbytes_q <= META_BYTES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PAGE_COUNT: begin
					pcov_q <= ({15'd0, cfg_data[16:0]} > 32'(MAX_PAGES)) ?
						PCOV_W'(MAX_PAGES) : PCOV_W'(cfg_data[16:0]);
				end
				CFG_KERNEL_START: ks_q     <= cfg_data;
				CFG_KERNEL_END:   ke_q     <= cfg_data;
				CFG_META_BASE:    mb_q     <= cfg_data;
				CFG_META_BYTES:   mbytes_q <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	// sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q       <= '0;
			phase_q      <= PH_KERNEL;
			first_flag_q <= 1'b0;
			cnt_q        <= '0;
			ssb_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				S_INIT: byte_q <= byte_inc;
				S_IDLE: phase_q <= PH_KERNEL;
				S_SETUP: begin
					case (op_q)
						OP_MARK_ALL: byte_q <= '0;
						OP_ALLOC: begin
							byte_q <= alloc_start;
							cnt_q  <= nbytes;
						end
						default: begin
							if (rng_hit) begin
								byte_q       <= rng_first[PG_W-1:3];
								first_flag_q <= 1'b1;
							end else if (more_phase) begin
								phase_q <= phase_q + 2'd1;
							end
						end
					endcase
				end
				S_FILL: byte_q <= byte_inc;
				S_RNG_WR: begin
					first_flag_q <= 1'b0;
					if (!byte_last)      byte_q  <= byte_inc;
					else if (more_phase) phase_q <= phase_q + 2'd1;
				end
				S_ALLOC_CHK: begin
					if (byte_found) begin
						ssb_q <= byte_q[BYTE_AW-1:0];
					end else begin
						byte_q <= alloc_next;
						cnt_q  <= cnt_q - NB_W'(1);
					end
				end
				default: ;
			endcase

			// response valid: set on load, cleared on transfer
			if ((state_q == S_DONE) && (state_d == S_IDLE)) rsp_valid_q <= 1'b1;
			else if (rsp.ready)                             rsp_valid_q <= 1'b0;
		end
	end

	// request capture, range bounds and results
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					op_q         <= req.op;
					addr_q       <= req.addr;
					length_q     <= req.length;
					res_addr_q   <= '0;
					res_status_q <= STAT_DONE;
				end
			end
			S_SETUP: begin
				end_byte_q  <= last_m1[PG_W-1:3];
				first_bit_q <= rng_first[2:0];
				last_bit_q  <= last_m1[2:0];
				if ((op_q == OP_FREE) && free_bad) res_status_q <= STAT_IGNORED;
				if ((op_q == OP_ALLOC) && nb_zero) res_status_q <= STAT_OOM;
			end
			S_ALLOC_CHK: begin
				if (byte_found) begin
					res_addr_q <= 32'({byte_q[BYTE_AW-1:0], clr_bit, 12'd0});
				end else if (cnt_q == NB_W'(1)) begin
					res_status_q <= STAT_OOM;
				end
			end
			S_DONE: begin
				if (state_d == S_IDLE) begin
					rsp_page_addr_q <= res_addr_q;
					rsp_status_q    <= res_status_q;
				end
			end
			default: ;
		endcase
	end

	assign req.ready     = (state_q == S_IDLE);
	assign rsp.valid     = rsp_valid_q;
	assign rsp.page_addr = rsp_page_addr_q;
	assign rsp.status    = rsp_status_q;

endmodule
